FILE: sv/assert_macros.svh
// Assertion macros used by the checker file tstg_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent implies consequent in the next clock cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK_RST(label, clk, rst, (ante) |=> (cons), msg)

`endif

FILE: sv/tstg_pkg.sv
// ----------------------------------------------------------------------------
// tstg_pkg
// Types, constants and field widths of the Taylor sine table generator.
// ----------------------------------------------------------------------------
package tstg_pkg;

   localparam int IDX_W       = 12;
   localparam int VAL_W       = 32;
   localparam int SC_W        = 13;
   localparam int TC_W        = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 48;

   localparam int DEF_MAX_SAMPLES = 4096;
   localparam int DEF_MAX_TERMS   = 16;

   localparam logic [SC_W-1:0] SC_RESET = 13'd256;
   localparam logic [TC_W-1:0] TC_RESET = 5'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_COUNT   = 1'b1;

   // Q3.28 fixed point
   localparam int                       Q_FRAC   = 28;
   localparam int                       TWOPI_W  = 31;
   localparam logic [TWOPI_W-1:0]       TWO_PI_Q = 31'd1686629713;
   localparam logic signed [VAL_W-1:0]  PI_Q     = 32'sd843314857;
   localparam logic signed [VAL_W-1:0]  Q_ONE    = 32'sd268435456;

   // divider dividend width: 2*pi times a sample index
   localparam int ANG_W  = TWOPI_W + IDX_W;
   localparam int XMAG_W = 30;
   localparam int STEP_W = $clog2(ANG_W + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD_GO,
      ST_MOD_WAIT,
      ST_ANG_MUL,
      ST_ANG_GO,
      ST_ANG_WAIT,
      ST_CHECK,
      ST_FAC_GO,
      ST_FAC_WAIT,
      ST_MUL,
      ST_SCALE,
      ST_ACC,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_MOD,
      DIV_ANG,
      DIV_FAC
   } div_sel_type;

   typedef struct packed {
      logic        load_in;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_mod;
      logic        ang_mul;
      logic        take_ang;
      logic        take_fac;
      logic        do_mul;
      logic        do_scale;
      logic        do_acc;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic term_end;
      logic terms_done;
      logic out_busy;
   } stat_type;

endpackage

FILE: sv/taylor_sine_table_generator.sv
// ----------------------------------------------------------------------------
// taylor_sine_table_generator
// Sine of 2*pi*i/N as a truncated Taylor series, signed Q3.28.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat carries a sample index i (tdata[11:0]).
//   rsp_*  : one beat per request: echoed index and the Q3.28 sine value.
//   csr_*  : register writes, index 0 = sample_count N, 1 = term_count;
//            always ready, write only while no sample is in flight.
// Timing: one sample at a time. A bit-serial divider shared by the index
//   modulo, the angle division and every factor x/j sets the latency.
//   req_tready rises again as soon as the result is in the output register.
// Stall: a held result stays on rsp_* unchanged; the next sample can be
//   accepted and computed meanwhile and waits for the output register.
// Reset: sample_count = 256, term_count = 8, no result pending.
// ----------------------------------------------------------------------------
module taylor_sine_table_generator #(
   parameter int MAX_SAMPLES = tstg_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_TERMS   = tstg_pkg::DEF_MAX_TERMS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [tstg_pkg::REQ_DATA_W-1:0] req_tdata,   // [11:0] sample_index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tstg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // [11:0] echo_index,
                                                        // [43:12] sine_value
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tstg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tstg_pkg::CSR_DATA_W-1:0] csr_data
);
   import tstg_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   tstg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   tstg_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_TERMS   (MAX_TERMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

FILE: sv/tstg_div.sv
// ----------------------------------------------------------------------------
// tstg_div
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module tstg_div #(
   parameter int DVS_W = 13
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tstg_pkg::ANG_W-1:0]  dividend,
   input  logic [DVS_W-1:0]            divisor,
   input  logic [tstg_pkg::STEP_W-1:0] steps,
   output logic                        busy,
   output logic [tstg_pkg::ANG_W-1:0]  quotient,
   output logic [DVS_W-1:0]            remainder
);
   import tstg_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [ANG_W-1:0]    q_ff, q_in;
   logic [DVS_W-1:0]    r_ff, r_in;
   logic [DVS_W-1:0]    d_ff, d_in;
   logic [DVS_W:0]      trial;
   logic [DVS_W:0]      diff;
   logic                ge;

   always_comb begin
      trial = {r_ff, q_ff[ANG_W-1]};
      diff  = trial - {1'b0, d_ff};
      ge    = (trial >= {1'b0, d_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
      end else if (busy_ff) begin
         busy_in = (cnt_ff != STEP_W'(1));
         cnt_in  = cnt_ff - STEP_W'(1);
         q_in    = {q_ff[ANG_W-2:0], ge};
         r_in    = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

FILE: sv/tstg_datapath.sv
// ----------------------------------------------------------------------------
// tstg_datapath
// Config registers, angle and series arithmetic, result register.
// ----------------------------------------------------------------------------
module tstg_datapath #(
   parameter int MAX_SAMPLES = tstg_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_TERMS   = tstg_pkg::DEF_MAX_TERMS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tstg_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [tstg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   input  logic [tstg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tstg_pkg::CSR_DATA_W-1:0] csr_data,
   input  tstg_pkg::cmd_type               cmd,
   output tstg_pkg::stat_type              stat
);
   import tstg_pkg::*;

   localparam int NW    = $clog2(MAX_SAMPLES + 1);
   localparam int TW    = $clog2(MAX_TERMS + 1);
   localparam int JW    = $clog2(2 * MAX_TERMS + 1);
   localparam int DVS_W = (NW > JW) ? NW : JW;
   localparam int SUM_W = VAL_W + TW + 1;
   localparam int MUL_W = 2 * VAL_W;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
   localparam logic signed [MUL_W-1:0] TRUNC_BIAS = (MUL_W'(1) <<< Q_FRAC) - MUL_W'(1);

   logic [SC_W-1:0]            sc_ff, sc_in;
   logic [TC_W-1:0]            tc_ff, tc_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [NW-1:0]              n_ff, n_in;
   logic [TW-1:0]              terms_ff, terms_in;
   logic [IDX_W-1:0]           i_ff, i_in;
   logic [ANG_W-1:0]           angprod_ff, angprod_in;
   logic signed [VAL_W-1:0]    x_ff, x_in;
   logic signed [VAL_W-1:0]    fac_ff, fac_in;
   logic signed [MUL_W-1:0]    mul_ff, mul_in;
   logic signed [VAL_W-1:0]    prod_ff, prod_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [JW-1:0]              j_ff, j_in;
   logic [TW-1:0]              k_ff, k_in;
   logic                       rv_ff, rv_in;
   logic [IDX_W-1:0]           ri_ff, ri_in;
   logic [VAL_W-1:0]           rval_ff, rval_in;

   logic [NW-1:0]              n_clamp;
   logic [TW-1:0]              terms_clamp;
   logic [VAL_W-1:0]           xmag;
   logic [TWOPI_W-1:0]         angle;
   logic signed [VAL_W-1:0]    quo_s;
   logic signed [MUL_W-1:0]    biased;
   logic signed [MUL_W-1:0]    shifted;
   logic signed [SUM_W-1:0]    term_ext;

   logic                       div_start;
   logic [ANG_W-1:0]           div_dvd;
   logic [DVS_W-1:0]           div_dvs;
   logic [STEP_W-1:0]          div_steps;
   logic                       div_busy;
   logic [ANG_W-1:0]           div_quo;
   logic [DVS_W-1:0]           div_rem;

   // config writes
   always_comb begin
      sc_in = sc_ff;
      tc_in = tc_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_COUNT: sc_in = csr_data[SC_W-1:0];
            CSR_TERM_COUNT:   tc_in = csr_data[TC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (sc_ff == '0) begin
         n_clamp = NW'(1);
      end else if (32'(sc_ff) > 32'(MAX_SAMPLES)) begin
         n_clamp = NW'(MAX_SAMPLES);
      end else begin
         n_clamp = NW'(sc_ff);
      end
      terms_clamp = (32'(tc_ff) > 32'(MAX_TERMS)) ? TW'(MAX_TERMS) : TW'(tc_ff);
   end

   // divider operand select
   assign xmag = x_ff[VAL_W-1] ? VAL_W'(-x_ff) : VAL_W'(x_ff);

   always_comb begin
      div_start = cmd.div_start;
      case (cmd.div_sel)
         DIV_MOD: begin
            div_dvd   = {idx_ff, {(ANG_W-IDX_W){1'b0}}};
            div_dvs   = DVS_W'(n_ff);
            div_steps = STEP_W'(IDX_W);
         end
         DIV_ANG: begin
            div_dvd   = angprod_ff;
            div_dvs   = DVS_W'(n_ff);
            div_steps = STEP_W'(ANG_W);
         end
         DIV_FAC: begin
            div_dvd   = {xmag[XMAG_W-1:0], {(ANG_W-XMAG_W){1'b0}}};
            div_dvs   = DVS_W'(j_ff);
            div_steps = STEP_W'(XMAG_W);
         end
         default: begin
            div_dvd   = '0;
            div_dvs   = DVS_W'(1);
            div_steps = STEP_W'(1);
         end
      endcase
   end

   tstg_div #(
      .DVS_W (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .steps     (div_steps),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      angle    = div_quo[TWOPI_W-1:0];
      quo_s    = signed'(div_quo[VAL_W-1:0]);
      biased   = mul_ff + (mul_ff[MUL_W-1] ? TRUNC_BIAS : MUL_W'(0));
      shifted  = biased >>> Q_FRAC;
      term_ext = SUM_W'(prod_ff);

      idx_in     = idx_ff;
      n_in       = n_ff;
      terms_in   = terms_ff;
      i_in       = i_ff;
      angprod_in = angprod_ff;
      x_in       = x_ff;
      fac_in     = fac_ff;
      mul_in     = mul_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      ri_in      = ri_ff;
      rval_in    = rval_ff;

      if (cmd.load_in) begin
         idx_in   = req_tdata[IDX_W-1:0];
         n_in     = n_clamp;
         terms_in = terms_clamp;
         j_in     = JW'(1);
         k_in     = '0;
         prod_in  = Q_ONE;
         sum_in   = '0;
      end
      if (cmd.take_mod) begin
         i_in = IDX_W'(div_rem);
      end
      if (cmd.ang_mul) begin
         angprod_in = ANG_W'(TWO_PI_Q) * ANG_W'(i_ff);
      end
      if (cmd.take_ang) begin
         // fold to pi - x unless the angle is zero
         x_in = (angle == '0) ? '0 : PI_Q - signed'({1'b0, angle});
      end
      if (cmd.take_fac) begin
         fac_in = x_ff[VAL_W-1] ? -quo_s : quo_s;
      end
      if (cmd.do_mul) begin
         mul_in = fac_ff * prod_ff;
      end
      if (cmd.do_scale) begin
         prod_in = shifted[VAL_W-1:0];
         j_in    = j_ff + JW'(1);
      end
      if (cmd.do_acc) begin
         sum_in = k_ff[0] ? sum_ff - term_ext : sum_ff + term_ext;
         k_in   = k_ff + TW'(1);
      end
      if (cmd.load_out) begin
         ri_in = idx_ff;
         if (sum_ff > SAT_HI) begin
            rval_in = SAT_HI[VAL_W-1:0];
         end else if (sum_ff < SAT_LO) begin
            rval_in = SAT_LO[VAL_W-1:0];
         end else begin
            rval_in = sum_ff[VAL_W-1:0];
         end
      end

      rv_in = rv_ff;
      if (cmd.load_out) begin
         rv_in = 1'b1;
      end else if (rsp_tready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff <= SC_RESET;
         tc_ff <= TC_RESET;
         rv_ff <= 1'b0;
      end else begin
         sc_ff <= sc_in;
         tc_ff <= tc_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      terms_ff   <= terms_in;
      i_ff       <= i_in;
      angprod_ff <= angprod_in;
      x_ff       <= x_in;
      fac_ff     <= fac_in;
      mul_ff     <= mul_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      ri_ff      <= ri_in;
      rval_ff    <= rval_in;
   end

   // a term is complete once j has stepped to an even value
   assign stat.div_busy   = div_busy;
   assign stat.term_end   = ~j_ff[0];
   assign stat.terms_done = (k_ff == terms_ff);
   assign stat.out_busy   = rv_ff & ~rsp_tready;

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_W-VAL_W){1'b0}}, rval_ff, ri_ff};

endmodule

FILE: sv/tstg_ctrl.sv
// ----------------------------------------------------------------------------
// tstg_ctrl
// Sequencer: modulo, angle, then factor / multiply / scale per series step, accumulate per term, output.
// ----------------------------------------------------------------------------
module tstg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output tstg_pkg::cmd_type  cmd,
   input  tstg_pkg::stat_type stat
);
   import tstg_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_MOD_GO;
            end
         end
         ST_MOD_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_MOD;
            state_in      = ST_MOD_WAIT;
         end
         ST_MOD_WAIT: begin
            if (!stat.div_busy) begin
               cmd.take_mod = 1'b1;
               state_in     = ST_ANG_MUL;
            end
         end
         ST_ANG_MUL: begin
            cmd.ang_mul = 1'b1;
            state_in    = ST_ANG_GO;
         end
         ST_ANG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ANG;
            state_in      = ST_ANG_WAIT;
         end
         ST_ANG_WAIT: begin
            if (!stat.div_busy) begin
               cmd.take_ang = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.terms_done ? ST_OUT : ST_FAC_GO;
         end
         ST_FAC_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FAC;
            state_in      = ST_FAC_WAIT;
         end
         ST_FAC_WAIT: begin
            if (!stat.div_busy) begin
               cmd.take_fac = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.do_scale = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            if (stat.term_end) begin
               cmd.do_acc = 1'b1;
               state_in   = ST_CHECK;
            end else begin
               state_in   = ST_FAC_GO;
            end
         end
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: sv/tstg_checker.sv
// ----------------------------------------------------------------------------
// tstg_checker
// Port-level checks on the Taylor sine table generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tstg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tstg_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tstg_pkg::*;

   localparam int SIGN_BIT = IDX_W + VAL_W - 1;

   // stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled result beat changed")

   // one sample in flight: busy right after a request beat
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready,
      !req_tready, "request taken while a sample is in flight")

   // a fresh result frees the request side
   `ASSERT_CLK_RST(a_ready_after_rsp, clock, reset, $rose(rsp_tvalid) |-> req_tready,
      "not ready after result load")

   // the result value stays within [-4.0, 4.0) in Q3.28
   `ASSERT_CLK_RST(a_sine_range, clock, reset,
      rsp_tvalid |-> (rsp_tdata[SIGN_BIT] == rsp_tdata[SIGN_BIT-1]),
      "sine value out of range")

endmodule

bind taylor_sine_table_generator tstg_checker u_tstg_checker (.*);
